// ----- sv/tdcl_pkg.sv -----
package tdcl_pkg;

  // Lexer sizing. The state word packs index, terminal and produce bit.
  localparam int unsigned STATE_COUNT   = 64;
  localparam int unsigned TERMINAL_BITS = 8;
  localparam int unsigned POSITION_BITS = 32;

  localparam int unsigned IDX_BITS  = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
  localparam int unsigned WORD_BITS = IDX_BITS + TERMINAL_BITS + 1;

  // Fixed field widths of the ports.
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned TINDEX_BITS    = 12;
  localparam int unsigned WVAL_BITS      = 15;
  localparam int unsigned OUT_TERM_BITS  = 8;
  localparam int unsigned OUT_POS_BITS   = 32;
  localparam int unsigned CFG_DATA_BITS  = 15;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned IGN_TERM_BITS  = 8;

  // Table geometry.
  localparam int unsigned BYTE_DEPTH = 256;
  localparam int unsigned BYTE_AW    = $clog2(BYTE_DEPTH);
  localparam int unsigned COMP_DEPTH = STATE_COUNT * STATE_COUNT;
  localparam int unsigned COMP_AW    = $clog2(COMP_DEPTH);

  // Queues.
  localparam int unsigned IN_Q_DEPTH  = 4;
  localparam int unsigned IN_Q_PTR    = $clog2(IN_Q_DEPTH);
  localparam int unsigned IN_Q_CNT    = $clog2(IN_Q_DEPTH + 1);
  localparam int unsigned OUT_Q_DEPTH = 8;
  localparam int unsigned OUT_Q_PTR   = $clog2(OUT_Q_DEPTH);
  localparam int unsigned OUT_Q_CNT   = $clog2(OUT_Q_DEPTH + 1);

  typedef logic [WORD_BITS-1:0]     word_t;
  typedef logic [IDX_BITS-1:0]      idx_t;
  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef enum logic [1:0] {
    CMD_DATA      = 2'd0,
    CMD_LOAD_BYTE = 2'd1,
    CMD_LOAD_COMP = 2'd2,
    CMD_LOAD_ACC  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IDENTITY = 2'd0,
    REG_IGN_EN   = 2'd1,
    REG_IGN_TERM = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [BYTE_BITS-1:0]   byte_value;
    logic                   last;
    logic [TINDEX_BITS-1:0] table_index;
    logic [WVAL_BITS-1:0]   write_value;
  } in_t;

  typedef struct packed {
    logic                     is_token;
    logic [OUT_TERM_BITS-1:0] token_terminal;
    logic [OUT_POS_BITS-1:0]  token_start;
    logic [OUT_POS_BITS-1:0]  token_end;
    logic                     end_of_string;
    logic                     accepted;
  } res_t;

  // Classified item as it waits between the front and the back.
  typedef struct packed {
    cmd_e                   cmd;
    logic [BYTE_BITS-1:0]   byte_value;
    logic                   last;
    logic [TINDEX_BITS-1:0] table_index;
    word_t                  wval;
  } item_t;

  // Up to two results per byte, lane 0 always older than lane 1.
  typedef struct packed {
    logic [1:0] vld;
    res_t [1:0] res;
  } res_push_t;

endpackage

// ----- sv/tdcl_ram.sv -----
module tdcl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tdcl_front.sv -----
module tdcl_front import tdcl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  output logic  full,
  input  in_t   in_word_i,
  input  logic  pop_i,
  output logic  vld_o,
  output item_t item_o
);

  cmd_e  cmd;
  logic  keep;
  logic  enq;
  logic  deq;
  item_t item;

  item_t                q_q [IN_Q_DEPTH];
  logic [IN_Q_PTR-1:0]  wr_ptr_q, wr_ptr_d;
  logic [IN_Q_PTR-1:0]  rd_ptr_q, rd_ptr_d;
  logic [IN_Q_CNT-1:0]  cnt_q, cnt_d;

  // Loads that fall outside their table are dropped here and never reach the back.
  always_comb begin
    cmd = cmd_e'(in_word_i.cmd);
    unique case (cmd)
      CMD_DATA:      keep = 1'b1;
      CMD_LOAD_BYTE: keep = 32'(in_word_i.table_index) < 32'(BYTE_DEPTH);
      CMD_LOAD_COMP: keep = 32'(in_word_i.table_index) < 32'(COMP_DEPTH);
      CMD_LOAD_ACC:  keep = 32'(in_word_i.table_index) < 32'(STATE_COUNT);
      default:       keep = 1'b0;
    endcase
    item.cmd         = cmd;
    item.byte_value  = in_word_i.byte_value;
    item.last        = in_word_i.last;
    item.table_index = in_word_i.table_index;
    item.wval        = WORD_BITS'(in_word_i.write_value);
  end

  assign full  = (cnt_q == IN_Q_CNT'(IN_Q_DEPTH));
  assign vld_o = (cnt_q != '0);
  assign enq   = push && !full && keep;
  assign deq   = pop_i && vld_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (deq) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (enq && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!enq && deq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_q[wr_ptr_q] <= item;
    end
  end

  assign item_o = q_q[rd_ptr_q];

  a_in_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IN_Q_CNT'(IN_Q_DEPTH))
    else $error("input queue count exceeds its depth");

endmodule

// ----- sv/tdcl_back.sv -----
module tdcl_back import tdcl_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic                      q_vld_i,
  input  item_t                     q_item_i,
  output logic                      q_pop_o,
  input  logic                      space_ok_i,
  output res_push_t                 push_o
);

  function automatic logic idx_ok(idx_t i);
    return 32'(i) < 32'(STATE_COUNT);
  endfunction

  function automatic logic [TERMINAL_BITS-1:0] word_term(word_t w);
    return w[IDX_BITS +: TERMINAL_BITS];
  endfunction

  function automatic pos_t pos_inc(pos_t p);
    return (p == '1) ? p : p + 1'b1;
  endfunction

  // Configuration registers.
  word_t                    id_q;
  logic                     ign_en_q;
  logic [IGN_TERM_BITS-1:0] ign_term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q       <= '0;
      ign_en_q   <= 1'b0;
      ign_term_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IDENTITY: id_q       <= WORD_BITS'(cfg_wdata_i);
        REG_IGN_EN:   ign_en_q   <= cfg_wdata_i[0];
        REG_IGN_TERM: ign_term_q <= cfg_wdata_i[IGN_TERM_BITS-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic ignored(logic [TERMINAL_BITS-1:0] t,
                                   logic en, logic [IGN_TERM_BITS-1:0] it);
    return en && (32'(t) == 32'(it));
  endfunction

  // The whole pipeline moves as one when the result queue can take two words.
  logic en;
  assign en      = space_ok_i;
  assign q_pop_o = en && q_vld_i;

  // Head of the queue: byte table access.
  logic                 byte_we, byte_re;
  logic [BYTE_AW-1:0]   byte_addr;
  word_t                byte_rdata;

  assign byte_we   = q_pop_o && (q_item_i.cmd == CMD_LOAD_BYTE);
  assign byte_re   = q_pop_o && (q_item_i.cmd == CMD_DATA);
  assign byte_addr = (q_item_i.cmd == CMD_LOAD_BYTE) ?
                     q_item_i.table_index[BYTE_AW-1:0] : q_item_i.byte_value;

  tdcl_ram #(.WIDTH(WORD_BITS), .DEPTH(BYTE_DEPTH)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .re_i    (byte_re),
    .addr_i  (byte_addr),
    .wdata_i (q_item_i.wval),
    .rdata_o (byte_rdata)
  );

  // Second stage: composition table access.
  logic  s2_vld_q;
  item_t s2_item_q;
  logic  inside_q;

  // Third stage state.
  logic                   s3_vld_q;
  cmd_e                   s3_cmd_q;
  logic                   s3_last_q;
  logic                   s3_first_q;
  logic                   s3_oor_q;
  idx_t                   s3_ti_q;
  logic                   s3_wbit_q;
  logic                   s3_data;
  word_t                  comp_rdata;
  word_t                  c;
  word_t                  state_q, state_d;
  pos_t                   begin_q, begin_d;
  pos_t                   pos_q, pos_d;

  logic                   s2_data;
  logic                   s2_first;
  word_t                  prev_word;
  word_t                  left_word;
  idx_t                   ai, bi;
  logic                   s2_oor;
  logic                   comp_we, comp_re;
  logic [COMP_AW-1:0]     comp_addr;

  assign s3_data   = s3_vld_q && (s3_cmd_q == CMD_DATA);
  assign c         = s3_oor_q ? '0 : comp_rdata;
  // The running state of the byte just ahead is bypassed from the RAM output.
  assign prev_word = s3_data ? c : state_q;

  assign s2_data   = s2_vld_q && (s2_item_q.cmd == CMD_DATA);
  assign s2_first  = !inside_q;
  assign left_word = s2_first ? id_q : prev_word;
  assign ai        = left_word[IDX_BITS-1:0];
  assign bi        = byte_rdata[IDX_BITS-1:0];
  assign s2_oor    = !idx_ok(ai) || !idx_ok(bi);
  assign comp_we   = en && s2_vld_q && (s2_item_q.cmd == CMD_LOAD_COMP);
  assign comp_re   = en && s2_data;
  assign comp_addr = (s2_item_q.cmd == CMD_LOAD_COMP) ?
                     COMP_AW'(s2_item_q.table_index) :
                     COMP_AW'(COMP_AW'(bi) * COMP_AW'(STATE_COUNT) + COMP_AW'(ai));

  tdcl_ram #(.WIDTH(WORD_BITS), .DEPTH(COMP_DEPTH)) u_comp_ram (
    .clk_i   (clk_i),
    .we_i    (comp_we),
    .re_i    (comp_re),
    .addr_i  (comp_addr),
    .wdata_i (s2_item_q.wval),
    .rdata_o (comp_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      inside_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= q_vld_i;
      s3_vld_q <= s2_vld_q;
      if (s2_data) begin
        inside_q <= !s2_item_q.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_item_q  <= q_item_i;
      s3_cmd_q   <= s2_item_q.cmd;
      s3_last_q  <= s2_item_q.last;
      s3_first_q <= s2_first;
      s3_oor_q   <= s2_oor;
      s3_ti_q    <= s2_item_q.table_index[IDX_BITS-1:0];
      s3_wbit_q  <= s2_item_q.wval[0];
    end
  end

  // Third stage: token decisions and accept table access.
  logic       acc_we, acc_re, acc_rdata;
  idx_t       acc_addr;
  idx_t       c_idx;
  logic       r0_vld_d, r1_vld_d;
  res_t       r0_d, r1_d;
  logic       acc_oor_d;
  pos_t       begin_n, pos_n;
  logic [TERMINAL_BITS-1:0] t_prev, t_fin;

  assign c_idx    = c[IDX_BITS-1:0];
  assign acc_we   = en && s3_vld_q && (s3_cmd_q == CMD_LOAD_ACC);
  assign acc_re   = en && s3_data && s3_last_q;
  assign acc_addr = (s3_cmd_q == CMD_LOAD_ACC) ? s3_ti_q : c_idx;

  tdcl_ram #(.WIDTH(1), .DEPTH(STATE_COUNT)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .re_i    (acc_re),
    .addr_i  (acc_addr),
    .wdata_i (s3_wbit_q),
    .rdata_o (acc_rdata)
  );

  always_comb begin
    state_d   = state_q;
    begin_d   = begin_q;
    pos_d     = pos_q;
    begin_n   = begin_q;
    pos_n     = pos_q;
    r0_vld_d  = 1'b0;
    r1_vld_d  = 1'b0;
    r0_d      = '0;
    r1_d      = '0;
    t_prev    = word_term(state_q);
    t_fin     = word_term(c);
    acc_oor_d = !idx_ok(c_idx);
    if (s3_data) begin
      if (s3_first_q) begin
        begin_n = '0;
        pos_n   = POSITION_BITS'(1);
      end else begin
        if (c[WORD_BITS-1]) begin
          if (!ignored(t_prev, ign_en_q, ign_term_q)) begin
            r0_vld_d            = 1'b1;
            r0_d.is_token       = 1'b1;
            r0_d.token_terminal = OUT_TERM_BITS'(t_prev);
            r0_d.token_start    = OUT_POS_BITS'(begin_q);
            r0_d.token_end      = OUT_POS_BITS'(pos_q);
          end
          begin_n = pos_q;
        end
        pos_n = pos_inc(pos_q);
      end
      state_d = c;
      begin_d = begin_n;
      pos_d   = pos_n;
      if (s3_last_q) begin
        r1_vld_d           = 1'b1;
        r1_d.end_of_string = 1'b1;
        if (!ignored(t_fin, ign_en_q, ign_term_q)) begin
          r1_d.is_token       = 1'b1;
          r1_d.token_terminal = OUT_TERM_BITS'(t_fin);
          r1_d.token_start    = OUT_POS_BITS'(begin_n);
          r1_d.token_end      = OUT_POS_BITS'(pos_n);
        end
        state_d = '0;
        begin_d = '0;
        pos_d   = '0;
      end
    end
  end

  // Fourth stage: results wait here for the accept bit.
  logic [1:0] s4_vld_q;
  res_t       s4_r0_q, s4_r1_q;
  logic       s4_acc_oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= '0;
      begin_q  <= '0;
      pos_q    <= '0;
      s4_vld_q <= '0;
    end else if (en) begin
      state_q  <= state_d;
      begin_q  <= begin_d;
      pos_q    <= pos_d;
      s4_vld_q <= {r1_vld_d, r0_vld_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_r0_q      <= r0_d;
      s4_r1_q      <= r1_d;
      s4_acc_oor_q <= acc_oor_d;
    end
  end

  always_comb begin
    push_o.vld             = en ? s4_vld_q : 2'b00;
    push_o.res[0]          = s4_r0_q;
    push_o.res[1]          = s4_r1_q;
    push_o.res[1].accepted = acc_rdata && !s4_acc_oor_q;
  end

  a_lane0_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_vld_q[0] |-> (s4_r0_q.is_token && !s4_r0_q.end_of_string))
    else $error("boundary lane holds something other than a token");

  a_lane1_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_vld_q[1] |-> s4_r1_q.end_of_string)
    else $error("final lane word without end of string");

endmodule

// ----- sv/tdcl_out_queue.sv -----
module tdcl_out_queue import tdcl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  output logic      space_ok_o,
  output logic      empty,
  input  logic      pop,
  output res_t      out_word_o
);

  res_t                 q_q [OUT_Q_DEPTH];
  logic [OUT_Q_PTR-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_Q_PTR-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_Q_CNT-1:0] cnt_q, cnt_d;
  logic [OUT_Q_CNT-1:0] n_push;
  logic                 deq;

  assign empty      = (cnt_q == '0);
  assign deq        = pop && !empty;
  assign space_ok_o = (cnt_q <= OUT_Q_CNT'(OUT_Q_DEPTH - 2));
  assign n_push     = OUT_Q_CNT'(push_i.vld[0]) + OUT_Q_CNT'(push_i.vld[1]);

  always_comb begin
    wr_ptr_d = wr_ptr_q + OUT_Q_PTR'(n_push);
    rd_ptr_d = deq ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + n_push - OUT_Q_CNT'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // The final word lands right after the boundary token when both arrive together.
  always_ff @(posedge clk_i) begin
    if (push_i.vld[0]) begin
      q_q[wr_ptr_q] <= push_i.res[0];
    end
    if (push_i.vld[1]) begin
      q_q[wr_ptr_q + OUT_Q_PTR'(push_i.vld[0])] <= push_i.res[1];
    end
  end

  assign out_word_o = q_q[rd_ptr_q];

  a_out_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OUT_Q_CNT'(OUT_Q_DEPTH))
    else $error("result queue count exceeds its depth");

  a_out_q_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (deq && (push_i.vld == 2'b00)) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("result queue count did not drop on a lone pop");

endmodule

// ----- sv/table_driven_composing_lexer_unit.sv -----
// Table-driven composing lexer. Items are data bytes or table loads (byte-to-state,
// composition, accept); all are taken in order through one queue, so a load lands
// exactly between the bytes it was pushed between. One item is taken per cycle in
// steady state, while the result queue has room. The rate is set by the composition
// RAM: each byte makes one registered read whose address needs the state left by
// the byte before, which is bypassed straight from that RAM's read data. The lexing
// pipeline pauses whenever the result queue has fewer than two free words, and the
// input side then reports full once its four-entry queue fills. Loads beyond a
// table's depth are dropped. Tables have no reset and need no clearing pass; they
// must be loaded before use.
module table_driven_composing_lexer_unit import tdcl_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  in_t                       in_word_i,
  output logic                      empty,
  input  logic                      pop,
  output res_t                      out_word_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  logic      q_vld;
  item_t     q_item;
  logic      q_pop;
  logic      space_ok;
  res_push_t res_push;

  tdcl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_word_i (in_word_i),
    .pop_i     (q_pop),
    .vld_o     (q_vld),
    .item_o    (q_item)
  );

  tdcl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_vld_i     (q_vld),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .space_ok_i  (space_ok),
    .push_o      (res_push)
  );

  tdcl_out_queue u_out_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_push),
    .space_ok_o (space_ok),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

endmodule

// ----- dv/table_driven_composing_lexer_unit_tb.sv -----
module table_driven_composing_lexer_unit_tb;
  import tdcl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_500_000;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES = 300;
  // State words name only a few indices and strings use only a few byte values,
  // so a short fill covers every entry that a lookup can reach.
  localparam int unsigned USED_IDX = 4;
  localparam int unsigned BYTE_SET = 16;

  // Tracks the lexer's tables, running state and registers, and queues the
  // result words that each accepted input word should produce.
  class lex_scoreboard;
    word_t byte_states [BYTE_DEPTH];
    word_t compose_tab [COMP_DEPTH];
    bit    accept_bits [STATE_COUNT];
    word_t run_state;
    pos_t  tok_begin;
    pos_t  pos;
    bit    in_string;
    word_t ident_word;
    bit    ign_en;
    logic [IGN_TERM_BITS-1:0] ign_term;
    res_t  tokens_due [$];
    int unsigned mismatches;

    function new();
      run_state = '0;
      tok_begin = '0;
      pos = '0;
      in_string = 1'b0;
      ident_word = '0;
      ign_en = 1'b0;
      ign_term = '0;
      mismatches = 0;
    endfunction

    function idx_t idx_of(word_t w);
      return w[IDX_BITS-1:0];
    endfunction

    function logic [TERMINAL_BITS-1:0] term_of(word_t w);
      return w[IDX_BITS +: TERMINAL_BITS];
    endfunction

    function word_t compose(word_t a, word_t b);
      return compose_tab[int'(idx_of(b)) * STATE_COUNT + int'(idx_of(a))];
    endfunction

    function bit hidden(logic [TERMINAL_BITS-1:0] t);
      return ign_en && (t == ign_term);
    endfunction

    function pos_t step_pos(pos_t p);
      return (p == '1) ? p : p + 1'b1;
    endfunction

    function void add_token(bit tok, logic [TERMINAL_BITS-1:0] t, pos_t s, pos_t e,
                            bit eos, bit acc);
      res_t r;
      r = '0;
      r.is_token = tok;
      if (tok) begin
        r.token_terminal = t;
        r.token_start = s;
        r.token_end = e;
      end
      r.end_of_string = eos;
      r.accepted = acc;
      tokens_due.push_back(r);
    endfunction

    function void take_word(in_t w);
      word_t nxt;
      word_t c;
      logic [TERMINAL_BITS-1:0] t;
      case (w.cmd)
        CMD_LOAD_BYTE: begin
          if (w.table_index < BYTE_DEPTH)
            byte_states[w.table_index] = w.write_value[WORD_BITS-1:0];
        end
        CMD_LOAD_COMP: begin
          if (w.table_index < COMP_DEPTH)
            compose_tab[w.table_index] = w.write_value[WORD_BITS-1:0];
        end
        CMD_LOAD_ACC: begin
          if (w.table_index < STATE_COUNT)
            accept_bits[w.table_index] = w.write_value[0];
        end
        default: begin
          nxt = byte_states[w.byte_value];
          if (!in_string) begin
            run_state = compose(ident_word, nxt);
            tok_begin = '0;
            pos = step_pos('0);
            in_string = 1'b1;
          end else begin
            c = compose(run_state, nxt);
            // A produce bit closes the token that ends just before this byte.
            if (c[WORD_BITS-1]) begin
              t = term_of(run_state);
              if (!hidden(t)) add_token(1'b1, t, tok_begin, pos, 1'b0, 1'b0);
              tok_begin = pos;
            end
            run_state = c;
            pos = step_pos(pos);
          end
          if (w.last) begin
            t = term_of(run_state);
            add_token(!hidden(t), t, tok_begin, pos, 1'b1, accept_bits[idx_of(run_state)]);
            run_state = '0;
            tok_begin = '0;
            pos = '0;
            in_string = 1'b0;
          end
        end
      endcase
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing expected: %p", got);
        return;
      end
      want = tokens_due.pop_front();
      if (got.is_token !== want.is_token || got.token_terminal !== want.token_terminal ||
          got.token_start !== want.token_start || got.token_end !== want.token_end ||
          got.end_of_string !== want.end_of_string || got.accepted !== want.accepted) begin
        mismatches++;
        if (mismatches <= 10) $display("wrong result word: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push;
  logic full;
  in_t  in_word_i;
  logic empty;
  logic pop;
  res_t out_word_o;
  logic cfg_we_i;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;

  lex_scoreboard sb;
  int unsigned items_sent = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_off = 1'b0;

  table_driven_composing_lexer_unit u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .in_word_i(in_word_i),
    .empty(empty),
    .pop(pop),
    .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5ns clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm || hold_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(16, 48);
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 6);
    if (r < 97) return $urandom_range(7, 16);
    return $urandom_range(30, 60);
  endfunction

  // The lowest few indices and the top one.
  function automatic idx_t used_idx(int unsigned k);
    return (k < USED_IDX - 1) ? IDX_BITS'(k) : IDX_BITS'(STATE_COUNT - 1);
  endfunction

  function automatic logic [BYTE_BITS-1:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 90) return BYTE_BITS'($urandom_range(0, BYTE_SET - 1));
    if (r < 95) return 8'h5a;
    return 8'hff;
  endfunction

  // Mostly a few small terminal codes so that the ignored terminal is hit often.
  function automatic word_t rand_word();
    word_t w;
    int unsigned r;
    r = $urandom_range(0, 99);
    w[IDX_BITS-1:0] = used_idx($urandom_range(0, USED_IDX - 1));
    if (r < 70) w[IDX_BITS +: TERMINAL_BITS] = TERMINAL_BITS'($urandom_range(0, 3));
    else if (r < 85) w[IDX_BITS +: TERMINAL_BITS] = '1;
    else w[IDX_BITS +: TERMINAL_BITS] = TERMINAL_BITS'($urandom_range(0, 255));
    w[WORD_BITS-1] = ($urandom_range(0, 99) < 35);
    return w;
  endfunction

  function automatic logic [WVAL_BITS-1:0] rand_wval();
    return WVAL_BITS'($urandom_range(0, 32767));
  endfunction

  function automatic in_t data_word(logic [BYTE_BITS-1:0] b, bit last);
    in_t w;
    w.cmd = CMD_DATA;
    w.byte_value = b;
    w.last = last;
    w.table_index = TINDEX_BITS'($urandom_range(0, 4095));
    w.write_value = rand_wval();
    return w;
  endfunction

  function automatic in_t load_word(cmd_e c, int unsigned idx, logic [WVAL_BITS-1:0] v);
    in_t w;
    w.cmd = c;
    w.byte_value = BYTE_BITS'($urandom_range(0, 255));
    w.last = 1'($urandom_range(0, 1));
    w.table_index = TINDEX_BITS'(idx);
    w.write_value = v;
    return w;
  endfunction

  // Push is lowered only when a gap follows, so it never toggles within one step.
  task automatic send_word(in_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.take_word(w);
    items_sent++;
  endtask

  task automatic send_random_load();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)
      send_word(load_word(CMD_LOAD_COMP, $urandom_range(0, COMP_DEPTH - 1), rand_word()));
    else if (r < 65)
      send_word(load_word(CMD_LOAD_BYTE, $urandom_range(0, BYTE_DEPTH - 1), rand_word()));
    else if (r < 85)
      send_word(load_word(CMD_LOAD_ACC, $urandom_range(0, STATE_COUNT - 1), rand_wval()));
    else if (r < 92)
      send_word(load_word(CMD_LOAD_BYTE, $urandom_range(BYTE_DEPTH, 4095), rand_word()));
    else
      send_word(load_word(CMD_LOAD_ACC, $urandom_range(STATE_COUNT, 4095), rand_wval()));
  endtask

  task automatic send_string(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) send_random_load();
      send_word(data_word(rand_byte(), i == len - 1));
    end
  endtask

  // Loads leave nothing to wait for, so a few extra cycles cover the last one.
  task automatic settle();
    push <= 1'b0;
    while (sb.tokens_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(word_t ident, bit en, logic [IGN_TERM_BITS-1:0] term);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_IDENTITY;
    cfg_wdata_i <= ident;
    @(posedge clk_i);
    cfg_index_i <= REG_IGN_EN;
    cfg_wdata_i <= {14'($urandom), en};
    @(posedge clk_i);
    cfg_index_i <= REG_IGN_TERM;
    cfg_wdata_i <= {7'($urandom), term};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.ident_word = ident;
    sb.ign_en = en;
    sb.ign_term = term;
  endtask

  initial begin : stimulus
    int unsigned base;
    sb = new();
    rst_ni <= 1'b0;
    push <= 1'b0;
    in_word_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_IDENTITY;
    cfg_wdata_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    program_regs('0, 1'b0, '0);

    // Every entry that a lookup can reach is written before the first byte:
    // the bytes of the strings, each pair of used indices and the accept bits.
    for (int unsigned i = 0; i < BYTE_SET; i++)
      send_word(load_word(CMD_LOAD_BYTE, i, rand_word()));
    send_word(load_word(CMD_LOAD_BYTE, 8'h5a, rand_word()));
    send_word(load_word(CMD_LOAD_BYTE, 8'hff, rand_word()));
    for (int unsigned a = 0; a < USED_IDX; a++)
      for (int unsigned b = 0; b < USED_IDX; b++)
        send_word(load_word(CMD_LOAD_COMP,
                            STATE_COUNT * 32'(used_idx(b)) + 32'(used_idx(a)),
                            rand_word()));
    for (int unsigned i = 0; i < STATE_COUNT; i++)
      send_word(load_word(CMD_LOAD_ACC, i, rand_wval()));

    // Field extremes and loads beyond the depth of the byte and accept tables.
    send_word(load_word(CMD_LOAD_BYTE, 0, '1));
    send_word(load_word(CMD_LOAD_COMP, 4095, '0));
    send_word(load_word(CMD_LOAD_COMP, 0, '1));
    send_word(load_word(CMD_LOAD_ACC, STATE_COUNT - 1, '1));
    send_word(load_word(CMD_LOAD_ACC, 0, '0));
    send_word(load_word(CMD_LOAD_BYTE, BYTE_DEPTH, rand_word()));
    send_word(load_word(CMD_LOAD_BYTE, 4095, rand_word()));
    send_word(load_word(CMD_LOAD_ACC, STATE_COUNT, '1));
    send_word(load_word(CMD_LOAD_ACC, 4095, '1));
    // Strings of one byte both open and close, then a string of three bytes.
    send_word(data_word(8'h00, 1'b1));
    send_word(data_word(8'hff, 1'b1));
    send_word(data_word(8'h00, 1'b0));
    send_word(data_word(8'hff, 1'b0));
    send_word(data_word(8'h00, 1'b1));
    // A load between two bytes of an open string takes effect for the next byte.
    send_word(data_word(8'h5a, 1'b0));
    send_word(load_word(CMD_LOAD_BYTE, 8'h5a, rand_word()));
    send_word(data_word(8'h5a, 1'b0));
    send_word(data_word(8'h5a, 1'b1));

    for (int ph = 1; ph <= 4; ph++) begin
      settle();
      case (ph)
        1: program_regs('1, 1'b1, '1);
        2: program_regs(rand_word(), 1'b1, '0);
        3: program_regs(rand_word(), 1'b1, IGN_TERM_BITS'($urandom_range(0, 3)));
        default: program_regs(rand_word(), 1'b0, IGN_TERM_BITS'($urandom_range(0, 255)));
      endcase
      if (ph == 1) hold_req = 1'b1;
      base = items_sent;
      while (items_sent - base < PHASE_ITEMS) send_string(pick_len());
    end
    settle();

    if (sb.mismatches == 0 && sb.tokens_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : result_side
    int unsigned stall;
    stall = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_word(out_word_o);
      if (stall != 0) stall--;
      else stall = pick_gap();
      pop <= (stall == 0) && !hold_off;
    end
  end

  // One long stretch with the result side stalled while words keep coming,
  // so both internal queues fill and the input side reports full.
  initial begin : pressure
    wait (hold_req);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : calm_toggle
    forever begin
      repeat ($urandom_range(150, 500)) @(posedge clk_i);
      calm = !calm;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
